@@ design/btk_pkg.sv @@
package btk_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OUT_CNT_W = 7;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP_BEST  = 2'd1,
    OP_POP_WORST = 2'd2,
    OP_NOP       = 2'd3
  } op_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic              push;       // insert value in sorted place
    logic              grow;       // push extends the valid run by one
    logic              drop_first; // shift everything toward cell 0
    logic              drop_last;  // shorten the valid run by one
    logic [DATA_W-1:0] value;      // candidate, also compared every cycle
  } cell_ctrl_t;

endpackage

@@ design/btk_cell.sv @@
module btk_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  btk_pkg::cell_ctrl_t       ctrl,
  input  logic [btk_pkg::DATA_W-1:0] left_value,
  input  logic                      left_gt,
  input  logic                      left_valid,
  input  logic [btk_pkg::DATA_W-1:0] right_value,
  input  logic                      right_valid,
  output logic [btk_pkg::DATA_W-1:0] value,
  output logic                      valid,
  output logic                      gt
);
  import btk_pkg::*;

  logic [DATA_W-1:0] value_r, value_nxt;
  logic              valid_r, valid_nxt;

  // An empty cell acts as +infinity so the insertion point falls at the end.
  assign gt    = !valid_r || (value_r > ctrl.value);
  assign value = value_r;
  assign valid = valid_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.push) begin
      if (gt) begin
        value_nxt = left_gt ? left_value : ctrl.value;
      end
      if (ctrl.grow) begin
        valid_nxt = left_valid;
      end
    end else if (ctrl.drop_first) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.drop_last) begin
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

@@ design/bounded_top_k_selector.sv @@
// Bounded top-k selector: keeps the smallest unsigned 32-bit values pushed, up
// to cfg_capacity_in_use of them (written only while the store is empty;
// 0 reads as 1, values above CAPACITY saturate). The values sit in ascending
// order in a chain of CAPACITY cells; a push compares against every cell at
// once and each cell either holds, takes its left neighbor, or takes the new
// value, so a push inserts across the whole chain at once. Every beat
// returns one result beat with the accepted flag and the status after the
// step. The chain updates on the accept edge and the result register loads
// from the settled chain on the next edge (the wide worst-value select sits
// there). No new beat is taken while the chain settles; one is taken while
// the previous result waits only if the receiver takes it in the same cycle.
module bounded_top_k_selector #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_write_en,
  input  logic [6:0]                 cfg_capacity_in_use,
  // input beats
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_operation,
  input  logic [btk_pkg::DATA_W-1:0] in_value,
  // result beats
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_accepted,
  output logic [btk_pkg::DATA_W-1:0] out_best_value,
  output logic [btk_pkg::DATA_W-1:0] out_worst_value,
  output logic [6:0]                 out_held_count,
  output logic                       out_is_full,
  output logic                       out_is_empty
);
  import btk_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
  localparam int unsigned CAP_RST = (CAPACITY < 64) ? CAPACITY : 64;

  // Chain taps
  logic [DATA_W-1:0] cell_value [CAPACITY];
  logic              cell_valid [CAPACITY];
  logic              cell_gt    [CAPACITY];

  cell_ctrl_t        ctrl;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [CMP_W-1:0]  cfg_sat;
  logic              pend_r;
  logic              acc_r;
  logic              out_valid_r;
  logic              accept;
  logic              is_full;
  logic              replace_ok;
  logic              push_ok;
  logic [DATA_W-1:0] worst_sel;
  op_t               op;

  assign op       = op_t'(in_operation);
  assign in_ready = !pend_r && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == cap_r);

  // Candidate beats the worst held value: the last valid cell is greater.
  always_comb begin
    replace_ok = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == CAPACITY - 1) begin
        replace_ok = replace_ok | (cell_valid[i] & cell_gt[i]);
      end else begin
        replace_ok = replace_ok | (cell_valid[i] & !cell_valid[i+1] & cell_gt[i]);
      end
    end
  end

  // Decode the beat into a chain command and the next count.
  always_comb begin
    ctrl       = '0;
    ctrl.value = in_value;
    push_ok    = 1'b0;
    count_nxt  = count_r;
    if (accept) begin
      unique case (op)
        OP_PUSH: begin
          push_ok   = !is_full || replace_ok;
          ctrl.push = push_ok;
          ctrl.grow = !is_full;
          if (!is_full) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_POP_BEST: begin
          if (count_r != '0) begin
            push_ok         = 1'b1;
            ctrl.drop_first = 1'b1;
            count_nxt       = count_r - CNT_W'(1);
          end
        end
        OP_POP_WORST: begin
          if (count_r != '0) begin
            push_ok        = 1'b1;
            ctrl.drop_last = 1'b1;
            count_nxt      = count_r - CNT_W'(1);
          end
        end
        OP_NOP: begin
          push_ok = 1'b0;
        end
        default: begin
          push_ok = 1'b0;
        end
      endcase
    end
  end

  // Build the chain; cell 0 sees the new value as its left side, the last cell an empty right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] l_value, r_value;
    logic              l_gt, l_valid, r_valid;
    if (i == 0) begin : g_first
      assign l_value = in_value;
      assign l_gt    = 1'b0;
      assign l_valid = 1'b1;
    end else begin : g_mid_l
      assign l_value = cell_value[i-1];
      assign l_gt    = cell_gt[i-1];
      assign l_valid = cell_valid[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_value = cell_value[i];
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end
    btk_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_value  (l_value),
      .left_gt     (l_gt),
      .left_valid  (l_valid),
      .right_value (r_value),
      .right_valid (r_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // Saturate the requested capacity into 1..CAPACITY.
  always_comb begin
    cfg_sat = CMP_W'(cfg_capacity_in_use);
    if (cfg_sat == '0) begin
      cfg_sat = CMP_W'(1);
    end else if (cfg_sat > CMP_W'(CAPACITY)) begin
      cfg_sat = CMP_W'(CAPACITY);
    end
  end

  // Worst value: one-hot select on the end of the valid run.
  always_comb begin
    worst_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == CAPACITY - 1) begin
        worst_sel = worst_sel | (cell_valid[i] ? cell_value[i] : '0);
      end else begin
        worst_sel = worst_sel |
                    ((cell_valid[i] && !cell_valid[i+1]) ? cell_value[i] : '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CNT_W'(CAP_RST);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_write_en && (count_r == '0)) begin
        cap_r <= CNT_W'(cfg_sat);
      end
      // pend_r holds the beat while the chain settles, then the result loads.
      pend_r <= accept;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: accepted flag captured at accept, status from the chain.
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r <= push_ok;
    end
    if (pend_r) begin
      out_accepted    <= acc_r;
      out_best_value  <= cell_valid[0] ? cell_value[0] : '0;
      out_worst_value <= worst_sel;
      out_held_count  <= OUT_CNT_W'(count_r);
      out_is_full     <= is_full;
      out_is_empty    <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ bench/bounded_top_k_selector_tb.sv @@
module bounded_top_k_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btk_pkg::*;

  // Store depth of the instance; the capacity register saturates to it.
  localparam int unsigned STORE_DEPTH = 64;
  // Cycles with no beat on either channel before the run is given up.
  // The slowest correct stretch is a receiver stall across a pattern change,
  // a short sender gap or a settle pause, so this is many times over.
  localparam int unsigned QUIET_LIMIT = 2000;

  // Status reported with every result beat.
  typedef struct packed {
    logic                accepted;
    logic [DATA_W-1:0]   best_value;
    logic [DATA_W-1:0]   worst_value;
    logic [6:0]          held_count;
    logic                is_full;
    logic                is_empty;
  } store_status_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_write_en = 1'b0;
  logic [6:0]        cfg_capacity_in_use = 7'd0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_operation = OP_NOP;
  logic [DATA_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_accepted;
  logic [DATA_W-1:0] out_best_value;
  logic [DATA_W-1:0] out_worst_value;
  logic [6:0]        out_held_count;
  logic              out_is_full;
  logic              out_is_empty;

  // Shadow of the store: held values in ascending order plus the capacity.
  logic [DATA_W-1:0] kept_values[$];
  int unsigned       kept_limit = STORE_DEPTH;
  // Status beats still owed by the block, oldest first.
  store_status_t     pending_status[$];

  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;
  // Sender pacing: beats left in the current burst, and whether gaps occur.
  int unsigned       burst_left = 0;
  bit                gaps_on = 1'b0;
  // Receiver pacing: rotating ready pattern and cycles until it is redrawn.
  logic [15:0]       ready_pattern = 16'hFFFF;
  int unsigned       pattern_age = 0;
  store_status_t     want;

  always #5 clk = ~clk;

  bounded_top_k_selector #(
    .CAPACITY(STORE_DEPTH)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write_en        (cfg_write_en),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_accepted        (out_accepted),
    .out_best_value      (out_best_value),
    .out_worst_value     (out_worst_value),
    .out_held_count      (out_held_count),
    .out_is_full         (out_is_full),
    .out_is_empty        (out_is_empty)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Place a value in ascending order; equal values land after the existing
  // ones, which is invisible from outside anyway.
  function automatic void place_sorted(logic [DATA_W-1:0] v);
    int pos;
    pos = 0;
    while (pos < kept_values.size() && kept_values[pos] <= v)
      pos++;
    kept_values.insert(pos, v);
  endfunction

  // Apply one operation to the shadow store and return the status it reports.
  function automatic store_status_t apply_selector_op(op_t op, logic [DATA_W-1:0] v);
    store_status_t s;
    s = '0;
    case (op)
      OP_PUSH: begin
        if (kept_values.size() < kept_limit) begin
          place_sorted(v);
          s.accepted = 1'b1;
        end else if (kept_values.size() > 0 && v < kept_values[$]) begin
          // Full: evict the worst only for a strictly better candidate.
          void'(kept_values.pop_back());
          place_sorted(v);
          s.accepted = 1'b1;
        end
      end
      OP_POP_BEST: begin
        if (kept_values.size() > 0) begin
          void'(kept_values.pop_front());
          s.accepted = 1'b1;
        end
      end
      OP_POP_WORST: begin
        if (kept_values.size() > 0) begin
          void'(kept_values.pop_back());
          s.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    s.held_count = 7'(kept_values.size());
    s.is_empty   = (kept_values.size() == 0);
    s.is_full    = (kept_values.size() == kept_limit);
    if (!s.is_empty) begin
      s.best_value  = kept_values[0];
      s.worst_value = kept_values[$];
    end
    return s;
  endfunction

  // Capacity write: ignored unless the store is empty, then clamped to 1..depth.
  function automatic void apply_capacity(logic [6:0] w);
    if (kept_values.size() != 0)
      return;
    if (w == 0)
      kept_limit = 1;
    else if (w > STORE_DEPTH)
      kept_limit = STORE_DEPTH;
    else
      kept_limit = 32'(w);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
                                      logic [DATA_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    // Score the result beat taken at this edge against the oldest prediction.
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $error("result beat with nothing pending: best 0x%0h, count %0d",
               out_best_value, out_held_count);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("accepted", DATA_W'(want.accepted), DATA_W'(out_accepted));
        check_field("best_value",  want.best_value,  out_best_value);
        check_field("worst_value", want.worst_value, out_worst_value);
        check_field("held_count", DATA_W'(want.held_count), DATA_W'(out_held_count));
        check_field("is_full", DATA_W'(want.is_full), DATA_W'(out_is_full));
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_is_empty));
      end
    end
    // Redraw the stall pattern now and then: no stalls at all, a random
    // mix, or a single ready slot in the rotating 16-bit pattern.
    if (pattern_age == 0) begin
      case ($urandom_range(0, 2))
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'($urandom) | 16'h0001;
        default: ready_pattern = 16'h0001 << $urandom_range(0, 15);
      endcase
      pattern_age = $urandom_range(20, 80);
    end
    out_ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    pattern_age--;
  end

  // Watchdog: give up once neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bounded_top_k_selector: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Present one input beat, hold it until taken, then predict its status.
  // Leaves valid high; the caller either sends again or drops it.
  task automatic send_beat(op_t op, logic [DATA_W-1:0] v);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(apply_selector_op(op, v));
  endtask

  // Send in bursts of random length, with random gaps between them when gaps are on.
  task automatic send_paced(op_t op, logic [DATA_W-1:0] v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_valid <= 1'b0;
        in_value <= $urandom;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    burst_left--;
    send_beat(op, v);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline go quiet.
  task automatic settle_store();
    in_valid <= 1'b0;
    while (pending_status.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the capacity register; only called with the block idle.
  task automatic write_capacity(logic [6:0] w);
    cfg_write_en        <= 1'b1;
    cfg_capacity_in_use <= w;
    @(posedge clk);
    apply_capacity(w);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // Values lean toward extremes and a narrow band so ties and evictions happen.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(0, 15);
      5:       return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t pick_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      return OP_PUSH;
    case ($urandom_range(0, 20))
      0:       return OP_NOP;
      1, 3, 5, 7, 9, 11, 13, 15, 17, 19: return OP_POP_BEST;
      default: return OP_POP_WORST;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Removals and no-ops on an empty store, then value extremes at reset capacity.
  task automatic test_empty_store();
    send_beat(OP_NOP, '1);
    send_beat(OP_POP_BEST, '1);
    send_beat(OP_POP_WORST, '0);
    send_beat(OP_PUSH, '0);
    send_beat(OP_PUSH, '1);
    send_beat(OP_NOP, 32'h5A5A_A5A5);
    send_beat(OP_POP_BEST, '0);
    send_beat(OP_POP_WORST, '0);
    settle_store();
  endtask

  // Capacity clamping, ignored writes, and the full-store replacement rule.
  task automatic test_capacity_limits();
    // Zero clamps to one.
    write_capacity(7'd0);
    send_beat(OP_PUSH, 32'd9);
    send_beat(OP_PUSH, 32'd9);         // equal to worst: dropped
    send_beat(OP_PUSH, '1);            // above worst: dropped
    send_beat(OP_PUSH, 32'd4);         // better: replaces
    send_beat(OP_PUSH, '0);
    settle_store();
    // Store holds a value, so this write must not take effect.
    write_capacity(7'd5);
    send_beat(OP_PUSH, 32'd7);         // still full at one: dropped
    send_beat(OP_POP_BEST, 32'd0);
    settle_store();
    write_capacity(7'd2);
    send_beat(OP_PUSH, '1);
    send_beat(OP_PUSH, '1);
    send_beat(OP_PUSH, '1);            // full and tied with worst: dropped
    send_beat(OP_PUSH, 32'd1);
    send_beat(OP_POP_WORST, '0);
    send_beat(OP_POP_WORST, '0);
    settle_store();
    // Above the store depth clamps to the depth.
    write_capacity(7'd127);
    write_capacity(7'd65);
  endtask

  // Random traffic over several capacities, small ones mostly so the store
  // fills often; one long push-heavy phase asks for the whole depth.
  task automatic test_random_traffic();
    logic [6:0]  caps[8]  = '{7'd3, 7'd1, 7'd127, 7'd2, 7'd0, 7'd5, 7'd17, 7'd64};
    int unsigned beats[8] = '{60, 50, 160, 50, 40, 60, 60, 70};
    int unsigned push_pct;
    int unsigned drop;
    foreach (caps[p]) begin
      settle_store();
      // Usually empty the store so the new capacity sticks; otherwise the
      // write is dropped if it lands on a non-empty store.
      if ($urandom_range(0, 3) != 0) begin
        drop = kept_values.size();
        repeat (drop)
          send_beat($urandom_range(0, 1) ? OP_POP_BEST : OP_POP_WORST, $urandom);
        settle_store();
      end
      write_capacity(caps[p]);
      gaps_on  = ($urandom_range(0, 2) != 0);
      push_pct = (caps[p] > 16) ? 85 : $urandom_range(55, 80);
      repeat (beats[p])
        send_paced(pick_op(push_pct), pick_value());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Hold reset low from the start, then release it once.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_capacity_limits();
    test_random_traffic();

    // Drain every owed result before the verdict.
    settle_store();
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("bounded_top_k_selector: match");
    end else begin
      $display("bounded_top_k_selector: mismatch");
    end
    $finish;
  end

endmodule
